FILE: design/sbox_rotate_xor_body_cipher_assert.svh
// Assertion macros shared by the checker of the cipher block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SBOX_ROTATE_XOR_BODY_CIPHER_ASSERT_SVH
`define SBOX_ROTATE_XOR_BODY_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srx assertion failed");

// Next-cycle implication, disabled during reset.
`define SRX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srx assertion failed");

`endif

FILE: design/srx_pkg.sv
// Shared types, constants and S-box tables of the byte-stream cipher.
// No dependencies; imported by every module of the block.
package srx_pkg;

   localparam int LENGTH_BITS_DEF = 16;
   localparam int BLK_BYTES       = 16;
   localparam int Q_DEPTH         = 2;

   // Frame header bytes
   localparam logic [7:0] HDR_BYTE0   = 8'h74;
   localparam logic [7:0] HDR_BYTE1   = 8'h63;
   localparam logic [7:0] HDR_VERSION = 8'h02;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_KEY_WORD0   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD1   = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD2   = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD3   = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH  = 3'd4;
   localparam logic [2:0] CSR_DIRECTION   = 3'd5;
   localparam logic [2:0] CSR_BODY_LENGTH = 3'd6;

   localparam logic [7:0] FWD_BOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_BOX [0:255] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   typedef logic [BLK_BYTES-1:0][7:0] blk_type;

   // One unit of output work: optional header, then keep block bytes,
   // or a single error item.
   typedef struct packed {
      logic       hdr;
      logic [3:0] pad;
      blk_type    data;
      logic [4:0] keep;
      logic       last;
      logic       err;
      logic       inv;
   } job_type;

endpackage

FILE: design/sbox_rotate_xor_body_cipher.sv
// Byte-stream cipher with framing, top level: configuration registers and
// the key sweep, front end, job queue and output side. Uses srx_pkg.
//
// req_* carries message bytes in (tlast marks the final byte of a message);
// rsp_* carries framed ciphertext (encrypt) or recovered plain bytes
// (decrypt) out, with tuser flagging a malformed decrypt message. csr_*
// writes the seven registers: key words 0..3, key length, direction, body
// length, one write per cycle, no read-back.
// Throughput: one input item per cycle while the queue has room and no key
// sweep runs; the output side sends one item per cycle while rsp_tready is
// high. Encrypt sends 20 items for a message's first block (header
// included), so input pauses for each message. A finished block passes
// through the job queue, then the result register. Reset and every key or
// key-length write start a 16-byte key sweep, one key byte per cycle, during
// which req_tready is low. When the receiver stalls, the result register
// holds, the two-entry job queue fills and req_tready then drops.
module sbox_rotate_xor_body_cipher
   import srx_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] out_error
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [3:0][31:0] key_words_ff;
   logic [4:0]       key_len_ff;
   logic             dir_ff;
   logic [15:0]      body_len_ff;
   logic             key_restart;
   logic             key_busy;
   blk_type          round_key;
   logic             accept;
   logic             push;
   job_type          push_job;
   job_type          head;
   logic             q_valid;
   logic             q_full;
   logic             pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_words_ff <= '0;
         key_len_ff   <= 5'd16;
         dir_ff       <= 1'b0;
         body_len_ff  <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_KEY_WORD0:   key_words_ff[3] <= csr_wdata;
            CSR_KEY_WORD1:   key_words_ff[2] <= csr_wdata;
            CSR_KEY_WORD2:   key_words_ff[1] <= csr_wdata;
            CSR_KEY_WORD3:   key_words_ff[0] <= csr_wdata;
            CSR_KEY_LENGTH:  key_len_ff      <= csr_wdata[4:0];
            CSR_DIRECTION:   dir_ff          <= csr_wdata[0];
            CSR_BODY_LENGTH: body_len_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign key_restart = csr_we && (csr_addr <= CSR_KEY_LENGTH);
   assign req_tready  = !key_busy && !q_full;
   assign accept      = req_tvalid && req_tready;

   srx_key_sched u_key (
      .clock     (clock),
      .reset     (reset),
      .restart   (key_restart),
      .key_words (key_words_ff),
      .key_len   (key_len_ff),
      .busy      (key_busy),
      .round_key (round_key)
   );

   srx_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .direction   (dir_ff),
      .body_length (body_len_ff),
      .round_key   (round_key),
      .push        (push),
      .job         (push_job)
   );

   srx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .valid    (q_valid),
      .full     (q_full)
   );

   srx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (head),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_error (rsp_tuser)
   );

endmodule

FILE: design/srx_key_sched.sv
// Round key sweep: extends a short key with the inverse S-box chain and
// S-boxes every byte, one byte per cycle. Depends on srx_pkg.
module srx_key_sched
   import srx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [3:0][31:0] key_words,
   input  logic [4:0]       key_len,
   output logic             busy,
   output blk_type          round_key
);

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic [7:0] prev_ff;
   blk_type    key_ff;
   logic [31:0] word;
   logic [7:0]  raw_byte;
   logic [7:0]  chain_byte;
   logic        use_raw;

   // Raw byte of the current step, big-endian within its word
   assign word       = key_words[3 - step_ff[3:2]];
   assign raw_byte   = 8'(word >> {~step_ff[1:0], 3'b000});
   assign use_raw    = (step_ff == 4'd0) || ({1'b0, step_ff} < key_len);
   assign chain_byte = use_raw ? raw_byte : INV_BOX[prev_ff];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (restart) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff == 4'hF) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Key bytes, stored in big-endian byte order of the block
   always_ff @(posedge clock) begin
      if (busy_ff && !restart) begin
         key_ff[~step_ff] <= FWD_BOX[chain_byte];
         prev_ff <= chain_byte;
      end
   end

   assign busy      = busy_ff;
   assign round_key = key_ff;

endmodule

FILE: design/srx_front.sv
// Front end: takes message bytes, tracks framing, gathers 16-byte blocks
// and turns each finished block into a job for the output side. Uses srx_pkg.
module srx_front
   import srx_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic        direction,
   input  logic [15:0] body_length,
   input  blk_type     round_key,
   output logic        push,
   output job_type     job
);

   // Block byte i sits at byte position BLK_BYTES-1-i (big-endian)
   logic [3:0]             fill_ff, fill_in;
   logic [2:0]             hdr_cnt_ff, hdr_cnt_in;
   logic [3:0]             pad_ff, pad_in;
   logic                   pinv_ff, pinv_in;
   logic [LENGTH_BITS-1:0] seen_ff, seen_in;
   logic [7:0]             store_ff [BLK_BYTES];
   logic [7:0]             byte_m;
   logic [7:0]             blk [BLK_BYTES];
   logic [7:0]             kb [BLK_BYTES];
   blk_type                enc_blk, dec_blk;
   logic [3:0]             pad_e;
   logic                   end_msg;
   logic                   store_we;

   assign byte_m   = direction ? in_byte : FWD_BOX[in_byte];
   assign pad_e    = 4'(4'd0 - body_length[3:0]);
   assign store_we = accept && !(direction && !hdr_cnt_ff[2]);

   // Assemble the block: stored bytes, the new byte, then S-boxed zero pad
   always_comb begin
      for (int i = 0; i < BLK_BYTES; i++) begin
         kb[i] = round_key[BLK_BYTES - 1 - i];
         if (4'(i) < fill_ff)       blk[i] = store_ff[i];
         else if (4'(i) == fill_ff) blk[i] = byte_m;
         else                       blk[i] = FWD_BOX[0];
      end
   end

   // Word rotations are byte permutations within each word
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int p = 0; p < 4; p++) begin
            enc_blk[BLK_BYTES - 1 - (4 * k + p)] =
               blk[4 * k + ((p + k) % 4)] ^ kb[4 * k + p];
            dec_blk[BLK_BYTES - 1 - (4 * k + p)] =
               blk[4 * k + ((p + 4 - k) % 4)] ^ kb[4 * k + ((p + 4 - k) % 4)];
         end
      end
   end

   // Message state and job generation
   always_comb begin
      fill_in    = fill_ff;
      hdr_cnt_in = hdr_cnt_ff;
      pad_in     = pad_ff;
      pinv_in    = pinv_ff;
      seen_in    = seen_ff;
      end_msg    = 1'b0;
      push       = 1'b0;
      job        = '0;
      if (accept) begin
         if (seen_ff != '1) seen_in = seen_ff + 1'b1;
         if (!direction) begin
            if (hdr_cnt_ff == 3'd0) begin
               hdr_cnt_in = 3'd4;
               pad_in     = pad_e;
            end
            if (fill_ff == 4'hF || in_last) begin
               push      = 1'b1;
               job.hdr   = (hdr_cnt_ff == 3'd0);
               job.pad   = pad_e;
               job.data  = enc_blk;
               job.keep  = 5'd16;
               job.last  = in_last;
               fill_in   = '0;
            end else begin
               fill_in = fill_ff + 4'd1;
               // header goes out with the first byte
               if (hdr_cnt_ff == 3'd0) begin
                  push    = 1'b1;
                  job.hdr = 1'b1;
                  job.pad = pad_e;
               end
            end
            end_msg = in_last;
         end else if (!hdr_cnt_ff[2]) begin
            if (hdr_cnt_ff == 3'd3) begin
               pad_in  = in_byte[3:0];
               pinv_in = |in_byte[7:4];
            end
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
            if (in_last) begin
               push     = 1'b1;
               job.err  = 1'b1;
               job.last = 1'b1;
               end_msg  = 1'b1;
            end
         end else if (fill_ff == 4'hF) begin
            fill_in = '0;
            push    = 1'b1;
            if (in_last && pinv_ff) begin
               job.err  = 1'b1;
               job.last = 1'b1;
            end else begin
               job.data = dec_blk;
               job.keep = in_last ? 5'(5'd16 - {1'b0, pad_ff}) : 5'd16;
               job.last = in_last;
               job.inv  = 1'b1;
            end
            end_msg = in_last;
         end else if (in_last) begin
            push     = 1'b1;
            job.err  = 1'b1;
            job.last = 1'b1;
            end_msg  = 1'b1;
         end else begin
            fill_in = fill_ff + 4'd1;
         end
         if (end_msg) begin
            fill_in    = '0;
            hdr_cnt_in = '0;
            pad_in     = '0;
            pinv_in    = 1'b0;
            seen_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         hdr_cnt_ff <= '0;
         pad_ff     <= '0;
         pinv_ff    <= 1'b0;
         seen_ff    <= '0;
      end else begin
         fill_ff    <= fill_in;
         hdr_cnt_ff <= hdr_cnt_in;
         pad_ff     <= pad_in;
         pinv_ff    <= pinv_in;
         seen_ff    <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) store_ff[fill_ff] <= byte_m;
   end

endmodule

FILE: design/srx_queue.sv
// Short job queue between the front end and the output side.
// Uses job_type and Q_DEPTH from srx_pkg.
module srx_queue
   import srx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    valid,
   output logic    full
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   job_type          mem_ff [Q_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign wr_in  = push ? ((wr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
   assign rd_in  = pop  ? ((rd_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
   assign cnt_in = CW'(cnt_ff + CW'(push) - CW'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   assign head  = mem_ff[rd_ff];
   assign valid = (cnt_ff != '0);
   assign full  = (cnt_ff == CW'(Q_DEPTH));

endmodule

FILE: design/srx_back.sv
// Output side: walks the job at the queue head one byte per cycle, unless
// the receiver stalls, into a registered result stage. Uses srx_pkg.
module srx_back
   import srx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    head,
   output logic       pop,
   input  logic       out_ready,
   output logic       out_valid,
   output logic [7:0] out_byte,
   output logic       out_last,
   output logic       out_error
);

   logic [4:0] idx_ff, idx_in;
   logic       ov_ff, ov_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff;
   logic [4:0] total;
   logic [3:0] j;
   logic       in_hdr;
   logic       emit;
   logic       fin;
   logic [7:0] data_byte;

   assign total  = head.err ? 5'd1 : ((head.hdr ? 5'd4 : 5'd0) + head.keep);
   assign in_hdr = head.hdr && (idx_ff < 5'd4);
   assign j      = 4'(head.hdr ? idx_ff - 5'd4 : idx_ff);
   assign emit   = q_valid && (!ov_ff || out_ready);
   assign fin    = (idx_ff == 5'(total - 5'd1));
   assign pop    = emit && fin;

   // byte j of the block sits at position 15 - j
   assign data_byte = head.data[~j];

   // Select the next byte of the job
   always_comb begin
      priority if (head.err) begin
         byte_in = '0;
         last_in = 1'b1;
      end else if (in_hdr) begin
         unique case (idx_ff[1:0])
            2'd0: byte_in = HDR_BYTE0;
            2'd1: byte_in = HDR_BYTE1;
            2'd2: byte_in = HDR_VERSION;
            2'd3: byte_in = {4'b0, head.pad};
         endcase
         last_in = 1'b0;
      end else begin
         byte_in = head.inv ? INV_BOX[data_byte] : data_byte;
         last_in = head.last && ({1'b0, j} == 5'(head.keep - 5'd1));
      end
   end

   assign idx_in = emit ? (fin ? '0 : idx_ff + 5'd1) : idx_ff;
   assign ov_in  = emit ? 1'b1 : (out_ready ? 1'b0 : ov_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         err_ff  <= head.err;
      end
   end

   assign out_valid = ov_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_error = err_ff;

endmodule

FILE: design/srx_checker.sv
// Port-level checks of the cipher block, bound to the top level.
// Uses the assertion macros header and srx_pkg.
`include "sbox_rotate_xor_body_cipher_assert.svh"

module srx_checker
   import srx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser,
   input logic        csr_we,
   input logic [2:0]  csr_addr
);

   // A stalled result item holds
   `SRX_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // An error item ends its message and carries a zero byte
   `SRX_ASSERT_IMP(a_err_item, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == 8'd0))

   // The key sweep after reset keeps the input closed
   `SRX_ASSERT_IMP(a_reset_sweep, clock, reset, $past(reset), !req_tready)

   // A key write restarts the sweep
   `SRX_ASSERT_NXT(a_key_sweep, clock, reset, csr_we && (csr_addr <= CSR_KEY_LENGTH), !req_tready)

endmodule

bind sbox_rotate_xor_body_cipher srx_checker u_srx_checker (.*);
